>>> hw/rtl/stq_pkg.sv
// package for the sorted timer queue: codes, constants and state type
`timescale 1ns / 1ps
package stq_pkg;

    localparam int TIMER_SLOTS_DEF = 32;
    localparam int MAX_EMIT        = 32;
    localparam logic [31:0] DEADLINE_NONE = 32'hffff_ffff;

    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_FREE  = 3'd1;
    localparam logic [2:0] OP_BIND  = 3'd2;
    localparam logic [2:0] OP_ARM   = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_EXPIRY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_SLOT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] MARK_FREE  = 2'd0;
    localparam logic [1:0] MARK_ALLOC = 2'd1;
    localparam logic [1:0] MARK_ARMED = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_ALLOC    = 8'b0000_0010,
        S_ARM_SCAN = 8'b0000_0100,
        S_ARM_INS  = 8'b0000_1000,
        S_UPD      = 8'b0001_0000,
        S_RESP     = 8'b0010_0000,
        S_TCHK     = 8'b0100_0000,
        S_SPARE    = 8'b1000_0000
    } state_t;

endpackage

>>> hw/rtl/sorted_timer_queue_core.sv
// sorted timer queue: slot pool, deadline-ordered list and expiry sequencer
//
// usage: one command enters on the input channel (op, timer_id, dest_queue,
// tag, delay) when in_valid is high and in_stall is low. in_stall stays high
// from the transfer until the command has finished, so one command is worked
// at a time. results leave on the output channel through one output register;
// the receiver holds them back with out_stall and the sequencer waits.
// alloc scans the slot marks one per cycle; arm walks the ordered list one
// entry a cycle. a tick with no expiry gives no result; otherwise the expired
// entries leave from the head of the list, at most 32 expiries per tick, the
// last one flagged with last. out_stall can hold back each result.
// undefined ops are taken and dropped without a result.
// reset clears the tick count, the list length, the head deadline and all
// slot marks; queue, tag, deadline and list entries are undefined until
// written.
`timescale 1ns / 1ps
module sorted_timer_queue_core #(
    parameter int TIMER_SLOTS = stq_pkg::TIMER_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         op,
    input  logic [4:0]         timer_id,
    input  logic [7:0]         dest_queue,
    input  logic signed [31:0] tag,
    input  logic [31:0]        delay,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [1:0]         status,
    output logic [4:0]         slot,
    output logic [7:0]         out_queue,
    output logic signed [31:0] out_tag,
    output logic               last
);
    import stq_pkg::*;

    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    state_t state_reg, state_next;
    logic [31:0] tc_reg, tc_next;
    logic [31:0] nd_reg, nd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [5:0] emit_reg, emit_next;
    logic [2:0] op_reg, op_next;
    logic [IW-1:0] id_reg, id_next;
    logic [31:0] dl_reg, dl_next;
    logic [1:0] rs_status_reg, rs_status_next;
    logic [1:0] rs_kind_reg, rs_kind_next;
    logic [4:0] rs_slot_reg, rs_slot_next;
    logic pend_reg, pend_next;
    logic [4:0] p_slot_reg, p_slot_next;
    logic [7:0] p_q_reg, p_q_next;
    logic [31:0] p_tag_reg, p_tag_next;

    logic ov_reg, ov_next;
    logic [1:0] o_kind_reg, o_kind_next;
    logic [1:0] o_status_reg, o_status_next;
    logic [4:0] o_slot_reg, o_slot_next;
    logic [7:0] o_q_reg, o_q_next;
    logic [31:0] o_tag_reg, o_tag_next;
    logic o_last_reg, o_last_next;

    logic [IW-1:0] ol_reg [TIMER_SLOTS];
    logic [IW-1:0] ol_next [TIMER_SLOTS];
    logic [1:0] mark_reg [TIMER_SLOTS];
    logic [1:0] mark_next [TIMER_SLOTS];
    logic [31:0] dlm_reg [TIMER_SLOTS];
    logic [7:0] qm_reg [TIMER_SLOTS];
    logic [31:0] tagm_reg [TIMER_SLOTS];

    logic dl_we, bind_we;
    logic [IW-1:0] wr_addr;
    logic [31:0] dl_wdata;

    logic [6:0] id_ext;
    logic id_ok;
    logic out_free;
    logic [IW-1:0] head;
    logic [IW-1:0] scan_slot;
    logic [31:0] tc_inc;
    logic expire;

    assign id_ext = {2'b00, timer_id};
    assign id_ok = id_ext < 7'(TIMER_SLOTS);
    assign out_free = !ov_reg || !out_stall;
    assign head = ol_reg[0];
    assign scan_slot = ol_reg[idx_reg[IW-1:0]];
    assign tc_inc = tc_reg + 32'd1;
    assign expire = (cnt_reg != '0) && (emit_reg < 6'(MAX_EMIT))
                    && (dlm_reg[head] <= tc_reg);

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        tc_next = tc_reg;
        nd_next = nd_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        emit_next = emit_reg;
        op_next = op_reg;
        id_next = id_reg;
        dl_next = dl_reg;
        rs_status_next = rs_status_reg;
        rs_kind_next = rs_kind_reg;
        rs_slot_next = rs_slot_reg;
        pend_next = pend_reg;
        p_slot_next = p_slot_reg;
        p_q_next = p_q_reg;
        p_tag_next = p_tag_reg;
        ov_next = ov_reg && out_stall;
        o_kind_next = o_kind_reg;
        o_status_next = o_status_reg;
        o_slot_next = o_slot_reg;
        o_q_next = o_q_reg;
        o_tag_next = o_tag_reg;
        o_last_next = o_last_reg;
        ol_next = ol_reg;
        mark_next = mark_reg;
        dl_we = 1'b0;
        bind_we = 1'b0;
        wr_addr = id_ext[IW-1:0];
        dl_wdata = delay + tc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = op;
                    id_next = id_ext[IW-1:0];
                    rs_kind_next = KIND_ACK;
                    rs_status_next = ST_OK;
                    rs_slot_next = '0;
                    idx_next = '0;
                    unique case (op)
                        OP_ALLOC:
                        begin
                            rs_kind_next = KIND_ALLOC;
                            state_next = S_ALLOC;
                        end
                        OP_FREE:
                        begin
                            if (id_ok)
                            begin
                                mark_next[id_ext[IW-1:0]] = MARK_FREE;
                            end
                            state_next = S_RESP;
                        end
                        OP_BIND:
                        begin
                            bind_we = id_ok;
                            state_next = S_RESP;
                        end
                        OP_ARM:
                        begin
                            if (!id_ok)
                            begin
                                state_next = S_RESP;
                            end
                            else if (cnt_reg >= CW'(TIMER_SLOTS))
                            begin
                                rs_status_next = ST_FULL;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                dl_we = 1'b1;
                                dl_next = dl_wdata;
                                mark_next[id_ext[IW-1:0]] = MARK_ARMED;
                                state_next = S_ARM_SCAN;
                            end
                        end
                        OP_TICK:
                        begin
                            tc_next = tc_inc;
                            emit_next = '0;
                            pend_next = 1'b0;
                            if (nd_reg <= tc_inc)
                            begin
                                state_next = S_TCHK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (idx_reg == CW'(TIMER_SLOTS))
                begin
                    rs_status_next = ST_NO_SLOT;
                    state_next = S_RESP;
                end
                else if (mark_reg[idx_reg[IW-1:0]] == MARK_FREE)
                begin
                    mark_next[idx_reg[IW-1:0]] = MARK_ALLOC;
                    rs_slot_next = 5'(idx_reg);
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_ARM_SCAN:
            begin
                // stop at the first entry whose deadline is not below the new one
                if (idx_reg < cnt_reg && dlm_reg[scan_slot] < dl_reg)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    state_next = S_ARM_INS;
                end
            end
            S_ARM_INS:
            begin
                for (int j = 1; j < TIMER_SLOTS; j++)
                begin
                    if (CW'(j) > idx_reg && CW'(j) <= cnt_reg)
                    begin
                        ol_next[j] = ol_reg[j-1];
                    end
                end
                ol_next[idx_reg[IW-1:0]] = id_reg;
                cnt_next = cnt_reg + CW'(1);
                state_next = S_UPD;
            end
            S_UPD:
            begin
                nd_next = (cnt_reg == '0) ? DEADLINE_NONE : dlm_reg[head];
                state_next = (op_reg == OP_ARM) ? S_RESP : S_IDLE;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    o_kind_next = rs_kind_reg;
                    o_status_next = rs_status_reg;
                    o_slot_next = rs_slot_reg;
                    o_q_next = '0;
                    o_tag_next = '0;
                    o_last_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TCHK:
            begin
                // one expiry is held back until it is known whether it is the last
                if (!pend_reg || out_free)
                begin
                    if (pend_reg)
                    begin
                        ov_next = 1'b1;
                        o_kind_next = KIND_EXPIRY;
                        o_status_next = ST_OK;
                        o_slot_next = p_slot_reg;
                        o_q_next = p_q_reg;
                        o_tag_next = p_tag_reg;
                        o_last_next = !expire;
                    end
                    if (expire)
                    begin
                        pend_next = 1'b1;
                        p_slot_next = 5'(head);
                        p_q_next = qm_reg[head];
                        p_tag_next = tagm_reg[head];
                        mark_next[head] = MARK_ALLOC;
                        for (int j = 0; j < TIMER_SLOTS - 1; j++)
                        begin
                            ol_next[j] = ol_reg[j+1];
                        end
                        cnt_next = cnt_reg - CW'(1);
                        emit_next = emit_reg + 6'd1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        state_next = S_UPD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tc_reg <= '0;
            nd_reg <= DEADLINE_NONE;
            cnt_reg <= '0;
            idx_reg <= '0;
            emit_reg <= '0;
            op_reg <= OP_ALLOC;
            pend_reg <= 1'b0;
            ov_reg <= 1'b0;
            for (int i = 0; i < TIMER_SLOTS; i++)
            begin
                mark_reg[i] <= MARK_FREE;
            end
        end
        else
        begin
            state_reg <= state_next;
            tc_reg <= tc_next;
            nd_reg <= nd_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            emit_reg <= emit_next;
            op_reg <= op_next;
            pend_reg <= pend_next;
            ov_reg <= ov_next;
            mark_reg <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
        dl_reg <= dl_next;
        rs_status_reg <= rs_status_next;
        rs_kind_reg <= rs_kind_next;
        rs_slot_reg <= rs_slot_next;
        p_slot_reg <= p_slot_next;
        p_q_reg <= p_q_next;
        p_tag_reg <= p_tag_next;
        o_kind_reg <= o_kind_next;
        o_status_reg <= o_status_next;
        o_slot_reg <= o_slot_next;
        o_q_reg <= o_q_next;
        o_tag_reg <= o_tag_next;
        o_last_reg <= o_last_next;
        ol_reg <= ol_next;
        if (dl_we)
        begin
            dlm_reg[wr_addr] <= dl_wdata;
        end
        if (bind_we)
        begin
            qm_reg[wr_addr] <= dest_queue;
            tagm_reg[wr_addr] <= tag;
        end
    end

    assign out_valid = ov_reg;
    assign kind = o_kind_reg;
    assign status = o_status_reg;
    assign slot = o_slot_reg;
    assign out_queue = o_q_reg;
    assign out_tag = o_tag_reg;
    assign last = o_last_reg;

endmodule

>>> verif/sorted_timer_queue_core_tb.sv
// self-checking testbench for the sorted timer queue core
`timescale 1ns / 1ps
module sorted_timer_queue_core_tb;
    import stq_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [4:0]  slot;
        logic [7:0]  queue_id;
        logic [31:0] tag_val;
        logic        last;
    } timer_result_t;

    class timer_scoreboard;
        timer_result_t expected_results[$];
        int            mismatches;
        logic [31:0]   tick_now;
        logic [31:0]   head_deadline;
        int            listed;
        logic [4:0]    order[TIMER_SLOTS_DEF];
        logic [1:0]    mark[TIMER_SLOTS_DEF];
        logic [31:0]   deadline[TIMER_SLOTS_DEF];
        logic [7:0]    queue_of[TIMER_SLOTS_DEF];
        logic [31:0]   tag_of[TIMER_SLOTS_DEF];

        function new();
            mismatches    = 0;
            tick_now      = 0;
            head_deadline = DEADLINE_NONE;
            listed        = 0;
            foreach (mark[i])
            begin
                mark[i]     = MARK_FREE;
                order[i]    = 0;
                deadline[i] = 0;
                queue_of[i] = 0;
                tag_of[i]   = 0;
            end
        endfunction

        function void push(logic [1:0] k, logic [1:0] st, logic [4:0] s,
                           logic [7:0] q, logic [31:0] t, logic l);
            timer_result_t r;
            r = '{k, st, s, q, t, l};
            expected_results.push_back(r);
        endfunction

        function void refresh_head();
            head_deadline = (listed == 0) ? DEADLINE_NONE : deadline[order[0]];
        endfunction

        function void note_command(logic [2:0] cmd, logic [4:0] id, logic [7:0] q,
                                   logic [31:0] t, logic [31:0] dly);
            logic [31:0]   dl;
            logic [1:0]    st;
            int            pos;
            int            n;
            timer_result_t r;
            st = ST_OK;
            case (cmd)
                OP_ALLOC:
                begin
                    pos = -1;
                    for (int i = 0; i < TIMER_SLOTS_DEF; i++)
                        if (pos < 0 && mark[i] == MARK_FREE)
                            pos = i;
                    if (pos >= 0)
                    begin
                        mark[pos] = MARK_ALLOC;
                        push(KIND_ALLOC, ST_OK, pos[4:0], 0, 0, 1'b1);
                    end
                    else
                        push(KIND_ALLOC, ST_NO_SLOT, 0, 0, 0, 1'b1);
                end
                OP_FREE:
                begin
                    mark[id] = MARK_FREE;
                    push(KIND_ACK, ST_OK, 0, 0, 0, 1'b1);
                end
                OP_BIND:
                begin
                    queue_of[id] = q;
                    tag_of[id]   = t;
                    push(KIND_ACK, ST_OK, 0, 0, 0, 1'b1);
                end
                OP_ARM:
                begin
                    if (listed >= TIMER_SLOTS_DEF)
                        st = ST_FULL;
                    else
                    begin
                        dl           = dly + tick_now;
                        deadline[id] = dl;
                        mark[id]     = MARK_ARMED;
                        pos          = 0;
                        while (pos < listed && deadline[order[pos]] < dl)
                            pos++;
                        for (int j = listed; j > pos; j--)
                            order[j] = order[j-1];
                        order[pos] = id;
                        listed++;
                        refresh_head();
                    end
                    push(KIND_ACK, st, 0, 0, 0, 1'b1);
                end
                OP_TICK:
                begin
                    tick_now++;
                    if (head_deadline <= tick_now)
                    begin
                        n = 0;
                        while (n < listed && n < MAX_EMIT && deadline[order[n]] <= tick_now)
                        begin
                            mark[order[n]] = MARK_ALLOC;
                            push(KIND_EXPIRY, ST_OK, order[n], queue_of[order[n]],
                                 tag_of[order[n]], 1'b0);
                            n++;
                        end
                        listed -= n;
                        for (int j = 0; j < listed; j++)
                            order[j] = order[j+n];
                        refresh_head();
                        if (n > 0)
                        begin
                            r      = expected_results.pop_back();
                            r.last = 1'b1;
                            expected_results.push_back(r);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(timer_result_t got);
            timer_result_t want;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", got);
                return;
            end
            want = expected_results.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, actual %p", want, got);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         op;
    logic [4:0]         timer_id;
    logic [7:0]         dest_queue;
    logic signed [31:0] tag;
    logic [31:0]        delay;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         kind;
    logic [1:0]         status;
    logic [4:0]         slot;
    logic [7:0]         out_queue;
    logic signed [31:0] out_tag;
    logic               last;

    timer_scoreboard sb = new();
    int              burst_left;
    int unsigned     cycle_no;
    logic [31:0]     bound_mask;

    sorted_timer_queue_core dut (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver: phases of no stall, light stall and heavy stall
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{kind, status, slot, out_queue, out_tag, last});
        case ((cycle_no / 150) % 3)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 30);
            default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    // one transfer on the command channel, then maybe a gap
    task automatic issue_cmd(logic [2:0] c, logic [4:0] id, logic [7:0] q,
                             logic [31:0] t, logic [31:0] dly);
        op         <= c;
        timer_id   <= id;
        dest_queue <= q;
        tag        <= t;
        delay      <= dly;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_command(c, id, q, t, dly);
        if (c == OP_BIND)
            bound_mask[id] = 1'b1;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 10);
        end
    endtask

    task automatic issue_random();
        int          pick;
        logic [4:0]  id;
        logic [31:0] dly;
        pick = $urandom_range(0, 99);
        id   = 5'($urandom_range(0, 31));
        if (pick < 15)
            issue_cmd(OP_ALLOC, id, 8'($urandom), $urandom, $urandom);
        else if (pick < 25)
            issue_cmd(OP_FREE, id, 8'($urandom), $urandom, $urandom);
        else if (pick < 40 || (pick < 60 && !bound_mask[id]))
            issue_cmd(OP_BIND, id, 8'($urandom), $urandom, $urandom);
        else if (pick < 60)
        begin
            case ($urandom_range(0, 19))
                0:       dly = $urandom | 32'h8000_0000;
                1, 2:    dly = DEADLINE_NONE - $urandom_range(0, 20);
                default: dly = $urandom_range(0, 15);
            endcase
            issue_cmd(OP_ARM, id, 8'($urandom), $urandom, dly);
        end
        else
            issue_cmd(OP_TICK, id, 8'($urandom), $urandom, $urandom);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = OP_ALLOC;
        timer_id   = 0;
        dest_queue = 0;
        tag        = 0;
        delay      = 0;
        out_stall  = 1'b0;
        cycle_no   = 0;
        burst_left = 0;
        bound_mask = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, free of an armed slot, re-arm, wraparound deadline
        issue_cmd(OP_ALLOC, 0, 0, 0, 0);
        issue_cmd(OP_ALLOC, 0, 0, 0, 0);
        issue_cmd(OP_BIND, 0, 8'h00, 32'h8000_0000, 0);
        issue_cmd(OP_BIND, 31, 8'hff, 32'h7fff_ffff, 0);
        issue_cmd(OP_BIND, 1, 8'ha5, 32'hffff_ffff, 0);
        issue_cmd(OP_ARM, 0, 0, 0, 32'd0);
        issue_cmd(OP_TICK, 0, 0, 0, 0);
        issue_cmd(OP_ARM, 31, 0, 0, DEADLINE_NONE);
        issue_cmd(OP_ARM, 1, 0, 0, 32'd2);
        issue_cmd(OP_FREE, 1, 0, 0, 0);
        issue_cmd(OP_ARM, 0, 0, 0, 32'd2);
        issue_cmd(OP_ARM, 0, 0, 0, 32'd3);
        issue_cmd(OP_TICK, 0, 0, 0, 0);
        issue_cmd(OP_TICK, 0, 0, 0, 0);
        issue_cmd(OP_TICK, 0, 0, 0, 0);
        issue_cmd(OP_TICK, 0, 0, 0, 0);
        issue_cmd(3'd5, 0, 0, 0, 0);
        issue_cmd(3'd7, 31, 8'hff, 32'hffff_ffff, DEADLINE_NONE);
        issue_cmd(OP_FREE, 31, 0, 0, 0);
        issue_cmd(OP_FREE, 0, 0, 0, 0);

        // exhaust the pool, fill the list past full, then drain it
        for (int i = 0; i < 33; i++)
            issue_cmd(OP_ALLOC, 0, 0, 0, 0);
        for (int i = 0; i < 32; i++)
            issue_cmd(OP_BIND, 5'(i), 8'($urandom), $urandom, 0);
        for (int i = 0; i < 33; i++)
            issue_cmd(OP_ARM, 5'($urandom_range(0, 31)), 0, 0, $urandom_range(1, 6));
        for (int i = 0; i < 8; i++)
            issue_cmd(OP_TICK, 0, 0, 0, 0);
        for (int i = 0; i < 32; i++)
            issue_cmd(OP_FREE, 5'(i), 0, 0, 0);

        for (int i = 0; i < 140; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                issue_cmd(3'($urandom_range(5, 7)), 5'($urandom), 8'($urandom),
                          $urandom, $urandom);
            issue_random();
        end
        in_valid <= 1'b0;

        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("simulation failed");
        $finish;
    end
endmodule
